FILE: hw/rtl/upd_pkg.sv
// Package for the URL percent decoder: escape phases, character and capacity
// constants, the result bundle and queue status types and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package upd_pkg;

	// Escape tracking phases.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam int unsigned CAP_W     = 13;
	localparam int unsigned COUNT_W   = 12;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;
	localparam logic [CAP_W-1:0] CAP_MAX   = 13'd4096;

	// All results caused by one input item. n counts them (1 to 3); when
	// term is set the final one is the terminator.
	typedef struct packed {
		logic [1:0]      n;
		logic            term;
		logic [2:0][7:0] bytes;
	} bundle_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/url_percent_decoder_core.sv
// Top level of the streaming form-urlencoded decoder: joins the front part,
// the bundle queue and the back part. Depends on upd_pkg and those modules.
`timescale 1ns / 1ps

// The decoder takes one source byte per item and decodes it as form-urlencoded
// text: a plus becomes a space, a percent sign with two hex digits becomes one
// byte, and a broken escape is passed on literally before the breaking byte is
// handled normally. An item with end_of_string set flushes any held escape and
// yields a terminator result (byte zero); the last result of every item has
// last set, and an item may yield no result at all once the cap is reached or
// while an escape is being collected. The front part takes an item in every
// cycle in which the bundle queue has room, so input runs at one item per
// cycle; the back part delivers one result per cycle through its output
// register whenever the output is taken, so an item that yields two or three
// results is delivered one result after another and the queue of QUEUE_DEPTH
// bundles absorbs such bursts. The first result of an item is written into a
// queue entry and then loaded into the output register before it is presented.
// The capacity register (reset 256) may be written through cfg_we and
// cfg_wdata whenever the block is idle; it takes effect on the next item.

module url_percent_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_string,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      is_terminator,
	output logic                      last,
	input  logic                      cfg_we,
	input  logic [upd_pkg::CAP_W-1:0] cfg_wdata
);
	import upd_pkg::*;

	logic      push, pop;
	bundle_t   push_data, head;
	q_status_t q_status;

	// Front: escape state, cap tracking and bundle assembly.
	upd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_status      (q_status),
		.push          (push),
		.push_data     (push_data)
	);

	// Bundles wait here so that either side can stall on its own.
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	// Back: one result per cycle out of the head bundle while the output is taken.
	upd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.is_terminator (is_terminator),
		.last          (last)
	);

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("bundle pushed into a full queue");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("bundle popped from an empty queue");

	// A terminator is always the final result of its item and carries zero.
	a_term_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_terminator |-> last && (out_byte == 8'h00))
		else $error("malformed terminator result");

	// A pushed bundle is never empty; a terminator bundle always has at least the terminator slot.
	a_bundle_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.n != 2'd0) && (!push_data.term || push_data.n >= 2'd1))
		else $error("empty bundle pushed");

	// A result that is held back stays in the output register.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled result changed");

endmodule

FILE: hw/rtl/upd_front.sv
// Front part of the URL percent decoder: takes input items, tracks escapes and
// the output cap, and builds one result bundle per item that yields a result. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_string,
	input  logic                       cfg_we,
	input  logic [upd_pkg::CAP_W-1:0]  cfg_wdata,
	input  upd_pkg::q_status_t         q_status,
	output logic                       push,
	output upd_pkg::bundle_t           push_data
);
	import upd_pkg::*;

	logic [CAP_W-1:0]   cap_q;
	logic [1:0]         phase_q, phase_d;
	logic [7:0]         held_q, held_d;
	logic [COUNT_W-1:0] count_q, count_d;

	logic [2:0][7:0]    cand;
	logic [1:0]         ncand;
	logic               plain;
	logic [4:0]         hex_b, hex_h;
	logic [CAP_W-1:0]   cap_eff, cap_m1;
	logic [COUNT_W-1:0] data_cap, room;
	logic [1:0]         allowed;
	logic               accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	// Escape and plus decoding: gather up to three candidate data bytes.
	always_comb begin
		hex_b   = hex_decode(data_byte);
		hex_h   = hex_decode(held_q);
		cand    = '0;
		ncand   = 2'd0;
		phase_d = phase_q;
		held_d  = held_q;
		plain   = 1'b1;
		if (end_of_string) begin
			if (phase_q == PH_PCT || phase_q == PH_DIGIT) begin
				cand[0] = CHAR_PCT;
				ncand   = 2'd1;
			end
			if (phase_q == PH_DIGIT) begin
				cand[1] = held_q;
				ncand   = 2'd2;
			end
			phase_d = PH_IDLE;
			held_d  = 8'd0;
		end else begin
			case (phase_q)
				PH_PCT: begin
					if (hex_b[4]) begin
						held_d  = data_byte;
						phase_d = PH_DIGIT;
						plain   = 1'b0;
					end else begin
						cand[0] = CHAR_PCT;
						ncand   = 2'd1;
						phase_d = PH_IDLE;
					end
				end
				PH_DIGIT: begin
					if (hex_b[4]) begin
						cand[0] = {(hex_h[4] ? hex_h[3:0] : 4'd0), hex_b[3:0]};
						ncand   = 2'd1;
						plain   = 1'b0;
					end else begin
						cand[0] = CHAR_PCT;
						cand[1] = held_q;
						ncand   = 2'd2;
					end
					phase_d = PH_IDLE;
					held_d  = 8'd0;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (plain) begin
				if (data_byte == CHAR_PLUS) begin
					cand[ncand] = CHAR_SPACE;
					ncand       = ncand + 2'd1;
				end else if (data_byte == CHAR_PCT) begin
					phase_d = PH_PCT;
				end else begin
					cand[ncand] = data_byte;
					ncand       = ncand + 2'd1;
				end
			end
		end
	end

	// Cap: clamp the capacity, then keep only as many data bytes as fit.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = cap_q;
		end
		cap_m1   = cap_eff - CAP_W'(1);
		data_cap = cap_m1[COUNT_W-1:0];
		room     = data_cap - count_q;
		if (count_q >= data_cap) begin
			allowed = 2'd0;
		end else if (room < {{(COUNT_W-2){1'b0}}, ncand}) begin
			allowed = room[1:0];
		end else begin
			allowed = ncand;
		end
	end

	always_comb begin
		push_data.n    = allowed + {1'b0, end_of_string};
		push_data.term = end_of_string;
		for (int i = 0; i < 3; i++) begin
			push_data.bytes[i] = (2'(i) < allowed) ? cand[i] : 8'h00;
		end
		count_d = end_of_string ? '0 : count_q + {{(COUNT_W-2){1'b0}}, allowed};
	end

	assign push = accept && (push_data.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_d;
				held_q  <= held_d;
				count_q <= count_d;
			end
		end
	end

endmodule

FILE: hw/rtl/upd_queue.sv
// Short queue of result bundles between the front and back parts of the URL
// percent decoder. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  upd_pkg::bundle_t   push_data,
	input  logic               pop,
	output upd_pkg::bundle_t   head,
	output upd_pkg::q_status_t q_status
);
	import upd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bundle_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign q_status.full  = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push = push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/upd_back.sv
// Back part of the URL percent decoder: unpacks each queued bundle into
// single results through an output register. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::bundle_t   head,
	input  upd_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               is_terminator,
	output logic               last
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q, term_q, last_q;
	logic [7:0] byte_q;
	logic       load, emit, final_res;

	assign load      = !valid_q || out_ready;
	assign emit      = load && !q_status.empty;
	assign final_res = (idx_q == head.n - 2'd1);
	assign pop       = emit && final_res;

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= head.bytes[idx_q];
			term_q <= head.term && final_res;
			last_q <= final_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				idx_q   <= final_res ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign is_terminator = term_q;
	assign last          = last_q;

endmodule
